// File: sv/plf_pkg.sv
// Shared types, constants and helper functions for the line follower controller.
// No dependencies; every other file in this folder refers to it by scoped names.
package plf_pkg;

   // Speed and correction limits.
   localparam int SpeedLimit    = 100;
   localparam int MinCorrection = 2;

   // Reciprocal of the gain divisor (100) in 20 fractional bits; exact for magnitudes
   // below 2**14.
   localparam int RecipScale = 10486;
   localparam int RecipShift = 20;

   // Number of line sensors and the index of the last one.
   localparam int SensorCount = 5;
   localparam logic [2:0] LastSensor = 3'(SensorCount - 1);

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_BASE_FOLLOW = 3'd0,
      REG_BASE_ARC    = 3'd1,
      REG_KP_FOLLOW   = 3'd2,
      REG_KD_FOLLOW   = 3'd3,
      REG_KP_ARC      = 3'd4,
      REG_KD_ARC      = 3'd5
   } reg_index_type;

   // Register reset values.
   localparam logic [6:0] BaseFollowReset = 7'd50;
   localparam logic [6:0] BaseArcReset    = 7'd40;
   localparam logic [7:0] KpFollowReset   = 8'd30;
   localparam logic [7:0] KdFollowReset   = 8'd18;
   localparam logic [7:0] KpArcReset      = 8'd60;
   localparam logic [7:0] KdArcReset      = 8'd30;

   // Configuration register contents.
   typedef struct packed {
      logic [6:0] base_follow;
      logic [6:0] base_arc;
      logic [7:0] kp_follow;
      logic [7:0] kd_follow;
      logic [7:0] kp_arc;
      logic [7:0] kd_arc;
   } cfg_type;

   // Operands for the shared multiply-accumulate unit: result = mul_a * mul_b + addend.
   typedef struct packed {
      logic signed [15:0] mul_a;
      logic signed [15:0] mul_b;
      logic signed [31:0] addend;
   } alu_req_type;

   // One finished result.
   typedef struct packed {
      logic        line_lost;
      logic signed [5:0] line_error;
      logic signed [7:0] speed_right;
      logic signed [7:0] speed_left;
   } result_type;

   // Position weight of each sensor, from the left-most (bit zero) to the right-most.
   function automatic logic signed [5:0] sensor_weight(input logic [2:0] idx);
      logic signed [5:0] w;
      case (idx)
         3'd0:    w = 6'sd20;
         3'd1:    w = 6'sd10;
         3'd2:    w = 6'sd0;
         3'd3:    w = -6'sd10;
         3'd4:    w = -6'sd20;
         default: w = 6'sd0;
      endcase
      return w;
   endfunction

endpackage

// File: sv/plf_alu.sv
// Shared multiply-accumulate unit of the line follower controller.
// Depends on plf_pkg for the operand struct.
module plf_alu (
   input  plf_pkg::alu_req_type req,
   output logic signed [31:0]   result
);

   logic signed [31:0] product;

   // One signed 16 by 16 multiply followed by one add.
   assign product = req.mul_a * req.mul_b;
   assign result  = product + req.addend;

endmodule

// File: sv/plf_seq.sv
// Sequencer and working registers for one control step of the line follower.
// Depends on plf_pkg and drives the shared unit in plf_alu.
module plf_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  plf_pkg::cfg_type     cfg,
   input  logic                 start,
   input  logic [4:0]           sensor_bits,
   input  logic                 gain_set,
   input  logic                 res_free,
   output logic                 ready,
   output logic                 done,
   output plf_pkg::result_type  result
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SCAN   = 9'b000000010,
      ST_DIV    = 9'b000000100,
      ST_PMUL   = 9'b000001000,
      ST_DMUL   = 9'b000010000,
      ST_SCALE  = 9'b000100000,
      ST_LEFT   = 9'b001000000,
      ST_RIGHT  = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   logic [4:0]         bits_ff, bits_in;
   logic               arc_ff, arc_in;
   logic [2:0]         idx_ff, idx_in;
   logic signed [6:0]  sum_ff, sum_in;
   logic [2:0]         hits_ff, hits_in;
   logic [2:0]         rem_ff, rem_in;
   logic [4:0]         quot_ff, quot_in;
   logic signed [5:0]  err_ff, err_in;
   logic signed [5:0]  prev_err_ff, prev_err_in;
   logic               lost_ff, lost_in;
   logic signed [15:0] acc_ff, acc_in;
   logic signed [8:0]  corr_ff, corr_in;
   logic signed [7:0]  left_ff, left_in;
   logic signed [7:0]  right_ff, right_in;

   plf_pkg::alu_req_type alu_req;
   logic signed [31:0]   alu_res;

   logic [6:0]         base_w;
   logic [7:0]         kp_w;
   logic [7:0]         kd_w;
   logic               sum_neg_w;
   logic [6:0]         sum_abs_w;
   logic [4:0]         sum_mag_w;
   logic [3:0]         rem_shift_w;
   logic               trial_ok_w;
   logic [4:0]         quot_next_w;
   logic [2:0]         hits_next_w;
   logic signed [6:0]  derr_w;
   logic [15:0]        acc_abs_w;
   logic [7:0]         q_w;
   logic signed [8:0]  corr_raw_w;
   logic signed [8:0]  corr_min_w;

   // Clamp a sum to the speed range.
   function automatic logic signed [7:0] saturate_speed(input logic signed [31:0] v);
      logic signed [7:0] s;
      if (v > 32'sd100) begin
         s = 8'(plf_pkg::SpeedLimit);
      end else if (v < -32'sd100) begin
         s = -8'(plf_pkg::SpeedLimit);
      end else begin
         s = v[7:0];
      end
      return s;
   endfunction

   plf_alu u_alu (
      .req    (alu_req),
      .result (alu_res)
   );

   // Gain set selection.
   assign base_w = arc_ff ? cfg.base_arc : cfg.base_follow;
   assign kp_w   = arc_ff ? cfg.kp_arc   : cfg.kp_follow;
   assign kd_w   = arc_ff ? cfg.kd_arc   : cfg.kd_follow;

   // Sign and magnitude of the weighted sum for the restoring divider.
   assign sum_neg_w   = sum_ff[6];
   assign sum_abs_w   = sum_neg_w ? 7'(-sum_ff) : 7'(sum_ff);
   assign sum_mag_w   = sum_abs_w[4:0];
   assign rem_shift_w = {rem_ff, sum_mag_w[idx_ff]};
   assign trial_ok_w  = ~alu_res[31];
   assign quot_next_w = {quot_ff[3:0], trial_ok_w};

   // Hit count including the sensor being scanned this cycle.
   assign hits_next_w = bits_ff[idx_ff] ? hits_ff : 3'(hits_ff + 3'd1);

   // Difference term.
   assign derr_w = 7'(err_ff) - 7'(prev_err_ff);

   // Scaling of the accumulated correction by one hundredth, truncated toward zero.
   assign acc_abs_w  = acc_ff[15] ? 16'(-acc_ff) : 16'(acc_ff);
   assign q_w        = alu_res[plf_pkg::RecipShift +: 8];
   assign corr_raw_w = acc_ff[15] ? -$signed({1'b0, q_w}) : $signed({1'b0, q_w});

   // A nonzero error always gives at least the minimum correction in its own sign.
   always_comb begin
      corr_min_w = corr_raw_w;
      if ((err_ff > 6'sd0) && (corr_raw_w < 9'(plf_pkg::MinCorrection))) begin
         corr_min_w = 9'(plf_pkg::MinCorrection);
      end else if ((err_ff < 6'sd0) && (corr_raw_w > -9'(plf_pkg::MinCorrection))) begin
         corr_min_w = -9'(plf_pkg::MinCorrection);
      end
   end

   // Operand selection for the shared unit.
   always_comb begin
      alu_req.mul_a  = 16'sd0;
      alu_req.mul_b  = 16'sd0;
      alu_req.addend = 32'sd0;
      unique case (state_ff)
         ST_SCAN: begin
            alu_req.mul_a  = 16'(plf_pkg::sensor_weight(idx_ff));
            alu_req.mul_b  = 16'sd1;
            alu_req.addend = 32'(sum_ff);
         end
         ST_DIV: begin
            alu_req.mul_a  = $signed({13'd0, hits_ff});
            alu_req.mul_b  = -16'sd1;
            alu_req.addend = $signed({28'd0, rem_shift_w});
         end
         ST_PMUL: begin
            alu_req.mul_a  = $signed({8'd0, kp_w});
            alu_req.mul_b  = 16'(err_ff);
         end
         ST_DMUL: begin
            alu_req.mul_a  = $signed({8'd0, kd_w});
            alu_req.mul_b  = 16'(derr_w);
            alu_req.addend = 32'(acc_ff);
         end
         ST_SCALE: begin
            alu_req.mul_a  = $signed({2'd0, acc_abs_w[13:0]});
            alu_req.mul_b  = 16'(plf_pkg::RecipScale);
         end
         ST_LEFT: begin
            alu_req.mul_a  = 16'(corr_ff);
            alu_req.mul_b  = 16'sd1;
            alu_req.addend = $signed({25'd0, base_w});
         end
         ST_RIGHT: begin
            alu_req.mul_a  = 16'(corr_ff);
            alu_req.mul_b  = -16'sd1;
            alu_req.addend = $signed({25'd0, base_w});
         end
         default: begin
         end
      endcase
   end

   // Sequencer: scan, divide unless the line is lost, multiply, scale, form both wheel commands, hand off.
   always_comb begin
      state_in    = state_ff;
      bits_in     = bits_ff;
      arc_in      = arc_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      hits_in     = hits_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      err_in      = err_ff;
      prev_err_in = prev_err_ff;
      lost_in     = lost_ff;
      acc_in      = acc_ff;
      corr_in     = corr_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      done        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               bits_in  = sensor_bits;
               arc_in   = gain_set;
               idx_in   = 3'd0;
               sum_in   = 7'sd0;
               hits_in  = 3'd0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!bits_ff[idx_ff]) begin
               sum_in = alu_res[6:0];
            end
            hits_in = hits_next_w;
            if (idx_ff == plf_pkg::LastSensor) begin
               if (hits_next_w == 3'd0) begin
                  err_in   = prev_err_ff;
                  lost_in  = 1'b1;
                  state_in = ST_PMUL;
               end else begin
                  lost_in  = 1'b0;
                  idx_in   = plf_pkg::LastSensor;
                  rem_in   = 3'd0;
                  quot_in  = 5'd0;
                  state_in = ST_DIV;
               end
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         ST_DIV: begin
            rem_in  = trial_ok_w ? alu_res[2:0] : rem_shift_w[2:0];
            quot_in = quot_next_w;
            if (idx_ff == 3'd0) begin
               err_in   = sum_neg_w ? -$signed({1'b0, quot_next_w})
                                    : $signed({1'b0, quot_next_w});
               state_in = ST_PMUL;
            end else begin
               idx_in = idx_ff - 3'd1;
            end
         end
         ST_PMUL: begin
            acc_in   = alu_res[15:0];
            state_in = ST_DMUL;
         end
         ST_DMUL: begin
            acc_in   = alu_res[15:0];
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            corr_in  = corr_min_w;
            state_in = ST_LEFT;
         end
         ST_LEFT: begin
            left_in  = saturate_speed(alu_res);
            state_in = ST_RIGHT;
         end
         ST_RIGHT: begin
            right_in = saturate_speed(alu_res);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (res_free) begin
               done        = 1'b1;
               prev_err_in = err_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and the kept error.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         prev_err_ff <= 6'sd0;
      end else begin
         state_ff    <= state_in;
         prev_err_ff <= prev_err_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      bits_ff  <= bits_in;
      arc_ff   <= arc_in;
      idx_ff   <= idx_in;
      sum_ff   <= sum_in;
      hits_ff  <= hits_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      err_ff   <= err_in;
      lost_ff  <= lost_in;
      acc_ff   <= acc_in;
      corr_ff  <= corr_in;
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign ready              = (state_ff == ST_IDLE);
   assign result.line_lost   = lost_ff;
   assign result.line_error  = err_ff;
   assign result.speed_right = right_ff;
   assign result.speed_left  = left_ff;

endmodule

// File: sv/pd_line_follower.sv
// One shared multiply-accumulate unit takes the weighted sum, the divider trials,
// the gain products, the scaling and both wheel sums; a lost line skips the divider.
// Requests are taken one at a time, only while the sequencer is idle; a new request
// is taken while an earlier result still waits in the output.
// Reset (synchronous, active high) loads the register reset values, clears the kept
// error to zero and empties the output stage.
module pd_line_follower (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] sensor_bits
   input  logic        req_tuser,   // [0] gain_set
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] speed_left, [15:8] speed_right,
                                    // [21:16] line_error, [22] line_lost
   // Configuration write port.
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   plf_pkg::cfg_type    cfg_ff, cfg_in;
   plf_pkg::result_type result;
   plf_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                seq_ready;
   logic                seq_done;
   logic                res_free;

   // Configuration register writes; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (plf_pkg::reg_index_type'(csr_addr))
            plf_pkg::REG_BASE_FOLLOW: cfg_in.base_follow = csr_wdata[6:0];
            plf_pkg::REG_BASE_ARC:    cfg_in.base_arc    = csr_wdata[6:0];
            plf_pkg::REG_KP_FOLLOW:   cfg_in.kp_follow   = csr_wdata;
            plf_pkg::REG_KD_FOLLOW:   cfg_in.kd_follow   = csr_wdata;
            plf_pkg::REG_KP_ARC:      cfg_in.kp_arc      = csr_wdata;
            plf_pkg::REG_KD_ARC:      cfg_in.kd_arc      = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_follow <= plf_pkg::BaseFollowReset;
         cfg_ff.base_arc    <= plf_pkg::BaseArcReset;
         cfg_ff.kp_follow   <= plf_pkg::KpFollowReset;
         cfg_ff.kd_follow   <= plf_pkg::KdFollowReset;
         cfg_ff.kp_arc      <= plf_pkg::KpArcReset;
         cfg_ff.kd_arc      <= plf_pkg::KdArcReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The output stage can take a new result when empty or being drained.
   assign res_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = seq_ready;

   plf_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .start       (req_tvalid & seq_ready),
      .sensor_bits (req_tdata[4:0]),
      .gain_set    (req_tuser),
      .res_free    (res_free),
      .ready       (seq_ready),
      .done        (seq_done),
      .result      (result)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

// File: verif/pd_line_follower_test.sv
// Self-checking testbench for the five-sensor line follower controller.
// Depends on plf_pkg and pd_line_follower; the expected wheel speeds come from a local predictor.
`timescale 1ns / 1ps

module pd_line_follower_test;

   localparam int CycleLimit    = 500000;
   localparam int GainDivisor   = 100;
   localparam int SettleCycles  = 20;
   localparam int PhaseRequests = 200;
   localparam int PhaseCount    = 8;
   localparam int ReportLimit   = 10;

   // Register indexes past the last register; writes there must change nothing.
   localparam logic [2:0] SpareIndexLow  = 3'd6;
   localparam logic [2:0] SpareIndexHigh = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [4:0] sensor_bits
   logic        req_tuser = 1'b0;    // [0] gain_set
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [7:0] speed_left, [15:8] speed_right,
                                     // [21:16] line_error, [22] line_lost
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = 3'd0;
   logic [7:0]  csr_wdata = 8'd0;

   // Local copy of the registers and of the kept error.
   plf_pkg::cfg_type shadow_regs;
   int kept_error = 0;

   plf_pkg::result_type expected_speeds[$];

   bit sender_gaps_on = 1'b1;
   bit receiver_stalls_on = 1'b1;
   int stall_left = 0;
   int requests_sent = 0;
   int directed_requests = 0;
   int results_checked = 0;
   int mismatches = 0;
   int settings_loaded = 0;

   pd_line_follower DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int clamp_speed(input int speed);
      if (speed > plf_pkg::SpeedLimit) return plf_pkg::SpeedLimit;
      if (speed < -plf_pkg::SpeedLimit) return -plf_pkg::SpeedLimit;
      return speed;
   endfunction

   // One control step: position error from the black sensors, PD correction, wheel speeds.
   function automatic plf_pkg::result_type steer_for_sensors(input logic [4:0] bits,
                                                            input logic arc);
      plf_pkg::result_type res;
      int weight_sum;
      int hits;
      int err;
      int derr;
      int corr;
      int base;
      int kp;
      int kd;
      int left;
      int right;
      weight_sum = 0;
      hits = 0;
      // Sensor i weighs 20 - 10*i; a zero bit means the sensor sees black.
      for (int i = 0; i < plf_pkg::SensorCount; i++) begin
         if (!bits[i]) begin
            weight_sum += 20 - 10 * i;
            hits++;
         end
      end
      base = arc ? int'(shadow_regs.base_arc) : int'(shadow_regs.base_follow);
      kp = arc ? int'(shadow_regs.kp_arc) : int'(shadow_regs.kp_follow);
      kd = arc ? int'(shadow_regs.kd_arc) : int'(shadow_regs.kd_follow);
      // With the line lost the kept error stands, so the difference term is zero.
      err = (hits > 0) ? weight_sum / hits : kept_error;
      derr = err - kept_error;
      kept_error = err;
      corr = (kp * err + kd * derr) / GainDivisor;
      // A nonzero error always steers by at least the minimum in its own direction.
      if (err > 0 && corr < plf_pkg::MinCorrection) begin
         corr = plf_pkg::MinCorrection;
      end else if (err < 0 && corr > -plf_pkg::MinCorrection) begin
         corr = -plf_pkg::MinCorrection;
      end
      left = clamp_speed(base + corr);
      right = clamp_speed(base - corr);
      res.speed_left = left[7:0];
      res.speed_right = right[7:0];
      res.line_error = err[5:0];
      res.line_lost = (hits == 0);
      return res;
   endfunction

   // Sends one request, after an optional gap, and records its expected result.
   task automatic send_request(input logic [4:0] bits, input logic arc,
                               input logic [2:0] pad = 3'b000);
      if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pad, bits};
      req_tuser <= arc;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_speeds.push_back(steer_for_sensors(bits, arc));
      requests_sent++;
   endtask

   // Drops the request valid and waits until every expected result has been checked.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (expected_speeds.size() != 0) @(posedge clock);
   endtask

   // Leaves the write enable high so that back-to-back writes need no second assignment.
   task automatic write_register(input logic [2:0] addr, input logic [7:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      case (addr)
         plf_pkg::REG_BASE_FOLLOW: shadow_regs.base_follow = value[6:0];
         plf_pkg::REG_BASE_ARC:    shadow_regs.base_arc = value[6:0];
         plf_pkg::REG_KP_FOLLOW:   shadow_regs.kp_follow = value;
         plf_pkg::REG_KD_FOLLOW:   shadow_regs.kd_follow = value;
         plf_pkg::REG_KP_ARC:      shadow_regs.kp_arc = value;
         plf_pkg::REG_KD_ARC:      shadow_regs.kd_arc = value;
         default: ;
      endcase
   endtask

   // Writes all six registers once the block has gone idle.
   task automatic load_settings(input logic [7:0] base_follow, input logic [7:0] base_arc,
                                input logic [7:0] kp_follow, input logic [7:0] kd_follow,
                                input logic [7:0] kp_arc, input logic [7:0] kd_arc);
      wait_for_drain();
      write_register(plf_pkg::REG_BASE_FOLLOW, base_follow);
      write_register(plf_pkg::REG_BASE_ARC, base_arc);
      write_register(plf_pkg::REG_KP_FOLLOW, kp_follow);
      write_register(plf_pkg::REG_KD_FOLLOW, kd_follow);
      write_register(plf_pkg::REG_KP_ARC, kp_arc);
      write_register(plf_pkg::REG_KD_ARC, kd_arc);
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   // Sensor patterns at the reset gains: lost line, edges, center, truncating averages.
   task automatic test_sensor_patterns();
      send_request(5'h1F, 1'b0);   // nothing seen with the kept error still zero
      send_request(5'h1E, 1'b1);   // left-most sensor only
      send_request(5'h1F, 1'b0);   // line lost after a left error
      send_request(5'h0F, 1'b1);   // right-most sensor only
      send_request(5'h00, 1'b0);   // every sensor on black
      send_request(5'h1B, 1'b1);   // center sensor only
      send_request(5'h1C, 1'b0);
      send_request(5'h17, 1'b1);
      send_request(5'h13, 1'b0);
      send_request(5'h14, 1'b1);   // positive average that truncates
      send_request(5'h05, 1'b0);   // negative average that truncates toward zero
      send_request(5'h01, 1'b1);
      send_request(5'h18, 1'b0);
   endtask

   // Largest and smallest register values, the write mask and writes past the last index.
   task automatic test_register_extremes();
      // Bases above the speed limit and the largest gains push a wheel into saturation.
      load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_request(5'h1E, 1'b0);
      send_request(5'h0F, 1'b1);
      send_request(5'h1F, 1'b0);
      // Zero gains leave only the minimum correction.
      load_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_request(5'h1D, 1'b0);
      send_request(5'h17, 1'b1);
      wait_for_drain();
      write_register(SpareIndexLow, 8'h55);
      write_register(SpareIndexHigh, 8'hAA);
      csr_we <= 1'b0;
      send_request(5'h1E, 1'b1);
   endtask

   // Bits above the sensor field must not change anything.
   task automatic test_padding_bits();
      load_settings(8'(plf_pkg::BaseFollowReset), 8'(plf_pkg::BaseArcReset),
                    plf_pkg::KpFollowReset, plf_pkg::KdFollowReset,
                    plf_pkg::KpArcReset, plf_pkg::KdArcReset);
      send_request(5'h1D, 1'b0, 3'b111);
      send_request(5'h1F, 1'b1, 3'b101);
      send_request(5'h07, 1'b1, 3'b010);
   endtask

   // Random sensor words over several register settings; the last phases run without idling.
   task automatic test_random_traffic();
      logic [7:0] vals [6];
      logic [4:0] bits;
      for (int phase = 0; phase < PhaseCount; phase++) begin
         for (int r = 0; r < 6; r++) begin
            case (phase)
               0: vals[r] = 8'($urandom_range(0, 100));
               1: vals[r] = 8'hFF;
               2: vals[r] = 8'h00;
               default: begin
                  case ($urandom_range(0, 3))
                     0: vals[r] = 8'h00;
                     1: vals[r] = 8'hFF;
                     default: vals[r] = 8'($urandom_range(0, 255));
                  endcase
               end
            endcase
         end
         load_settings(vals[0], vals[1], vals[2], vals[3], vals[4], vals[5]);
         sender_gaps_on = (phase < PhaseCount - 2) && (phase != 3);
         receiver_stalls_on = (phase < PhaseCount - 2) && (phase != 4);
         repeat (PhaseRequests) begin
            // The lost line is favored so that the kept error is exercised often.
            bits = ($urandom_range(0, 5) == 0) ? 5'h1F : 5'($urandom_range(0, 31));
            send_request(bits, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Field compare; only the first few mismatches are printed.
   task automatic compare_field(input string label, input int got, input int want);
      if (got != want) begin
         mismatches++;
         if (mismatches <= ReportLimit) begin
            $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                     label, results_checked, want, got);
         end
      end
   endtask

   // Result checker and receiver stall generator.
   always @(posedge clock) begin
      plf_pkg::result_type observed;
      plf_pkg::result_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed = rsp_tdata[22:0];
         if (expected_speeds.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
               $display("Unexpected result 0x%h with no request outstanding", rsp_tdata);
            end
         end else begin
            wanted = expected_speeds.pop_front();
            compare_field("speed_left", int'(observed.speed_left), int'(wanted.speed_left));
            compare_field("speed_right", int'(observed.speed_right),
                          int'(wanted.speed_right));
            compare_field("line_error", int'(observed.line_error), int'(wanted.line_error));
            compare_field("line_lost", int'(observed.line_lost), int'(wanted.line_lost));
         end
         results_checked++;
      end
      if (!receiver_stalls_on) begin
         stall_left = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (receiver_stalls_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("Timeout after %0d cycles with %0d results outstanding",
               CycleLimit, expected_speeds.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      shadow_regs.base_follow = plf_pkg::BaseFollowReset;
      shadow_regs.base_arc = plf_pkg::BaseArcReset;
      shadow_regs.kp_follow = plf_pkg::KpFollowReset;
      shadow_regs.kd_follow = plf_pkg::KdFollowReset;
      shadow_regs.kp_arc = plf_pkg::KpArcReset;
      shadow_regs.kd_arc = plf_pkg::KdArcReset;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_sensor_patterns();
      test_register_extremes();
      test_padding_bits();
      directed_requests = requests_sent;
      test_random_traffic();

      wait_for_drain();
      repeat (SettleCycles) @(posedge clock);
      if (expected_speeds.size() != 0) begin
         mismatches++;
         $display("%0d expected results never arrived", expected_speeds.size());
      end

      $display("Sent %0d requests (%0d directed) under %0d register settings, both gain sets,",
               requests_sent, directed_requests, settings_loaded + 1);
      $display("with request gaps and result stalls; %0d results checked, %0d mismatches.",
               results_checked, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
